@@ rtl/bcss_pkg.sv @@
`timescale 1ns / 1ps
package bcss_pkg;

   // configuration register indexes
   localparam logic CSR_TICKS_PER_SECOND = 1'b0;
   localparam logic CSR_BUTTON_LOCKOUT   = 1'b1;

   localparam int CSR_DATA_WIDTH = 16;

   localparam logic [15:0] TICKS_PER_SECOND_RESET = 16'd1000;
   localparam logic [15:0] BUTTON_LOCKOUT_RESET   = 16'd500;
   localparam logic [15:0] COUNT_MAX              = 16'hFFFF;

   // BCD time of day, 24-hour
   typedef struct packed {
      logic [1:0] hour_tens;
      logic [3:0] hour_units;
      logic [2:0] minute_tens;
      logic [3:0] minute_units;
      logic [2:0] second_tens;
      logic [3:0] second_units;
   } time_type;

   // 15:30:00
   localparam time_type TIME_RESET = '{
      hour_tens:    2'd1,
      hour_units:   4'd5,
      minute_tens:  3'd3,
      minute_units: 4'd0,
      second_tens:  3'd0,
      second_units: 4'd0
   };

   // seven-segment code, bit0 segment a .. bit6 segment g; non-decimal codes blank
   function automatic logic [6:0] seg_encode(input logic [3:0] digit);
      logic [6:0] seg;
      case (digit)
         4'd0:    seg = 7'h3F;
         4'd1:    seg = 7'h06;
         4'd2:    seg = 7'h5B;
         4'd3:    seg = 7'h4F;
         4'd4:    seg = 7'h66;
         4'd5:    seg = 7'h6D;
         4'd6:    seg = 7'h7D;
         4'd7:    seg = 7'h07;
         4'd8:    seg = 7'h7F;
         4'd9:    seg = 7'h6F;
         default: seg = 7'h00;
      endcase
      return seg;
   endfunction

endpackage

@@ rtl/bcss_channels.sv @@
`timescale 1ns / 1ps
// tick word: two button levels
interface bcss_req_if;
   logic valid;
   logic ready;
   logic press_show_min_sec;
   logic press_show_hour_min;

   modport source (output valid, output press_show_min_sec, output press_show_hour_min,
                   input ready);
   modport sink   (input valid, input press_show_min_sec, input press_show_hour_min,
                   output ready);
endinterface

// display word: one scanned digit
interface bcss_rsp_if;
   logic       valid;
   logic       ready;
   logic [6:0] segments;
   logic       decimal_point;
   logic [3:0] digit_enable;
   logic       showing_min_sec;
   logic       second_advanced;

   modport source (output valid, output segments, output decimal_point,
                   output digit_enable, output showing_min_sec, output second_advanced,
                   input ready);
   modport sink   (input valid, input segments, input decimal_point,
                   input digit_enable, input showing_min_sec, input second_advanced,
                   output ready);
endinterface

@@ rtl/bcss_timekeeper.sv @@
`timescale 1ns / 1ps
module bcss_timekeeper (
   input  logic                clock,
   input  logic                reset,
   input  logic                tick,
   input  logic [15:0]         ticks_per_second,
   output bcss_pkg::time_type  now_time,
   output logic                second_due
);
   import bcss_pkg::*;

   time_type    time_ff, time_in;
   logic [15:0] prescaler_ff, prescaler_in;
   logic [15:0] rate;

   // treat a zero rate as one
   assign rate       = (ticks_per_second == 16'd0) ? 16'd1 : ticks_per_second;
   assign second_due = (prescaler_ff >= rate);
   assign now_time   = time_ff;

   // ripple the BCD time forward by one second
   always_comb begin
      time_in = time_ff;
      if (time_ff.second_units < 4'd9) begin
         time_in.second_units = time_ff.second_units + 4'd1;
      end else begin
         time_in.second_units = 4'd0;
         if (time_ff.second_tens < 3'd5) begin
            time_in.second_tens = time_ff.second_tens + 3'd1;
         end else begin
            time_in.second_tens = 3'd0;
            if (time_ff.minute_units < 4'd9) begin
               time_in.minute_units = time_ff.minute_units + 4'd1;
            end else begin
               time_in.minute_units = 4'd0;
               if (time_ff.minute_tens < 3'd5) begin
                  time_in.minute_tens = time_ff.minute_tens + 3'd1;
               end else begin
                  time_in.minute_tens = 3'd0;
                  if (time_ff.hour_tens <= 2'd1 && time_ff.hour_units < 4'd9) begin
                     time_in.hour_units = time_ff.hour_units + 4'd1;
                  end else if (time_ff.hour_tens <= 2'd1) begin
                     time_in.hour_units = 4'd0;
                     time_in.hour_tens  = time_ff.hour_tens + 2'd1;
                  end else if (time_ff.hour_tens == 2'd2 && time_ff.hour_units < 4'd3) begin
                     time_in.hour_units = time_ff.hour_units + 4'd1;
                  end else begin
                     // midnight wrap
                     time_in.hour_units = 4'd0;
                     time_in.hour_tens  = 2'd0;
                  end
               end
            end
         end
      end
   end

   // advance the prescaler, restart it at one on a second
   assign prescaler_in = second_due ? 16'd1 : prescaler_ff + 16'd1;

   always_ff @(posedge clock) begin
      if (reset) begin
         time_ff      <= TIME_RESET;
         prescaler_ff <= 16'd0;
      end else if (tick) begin
         prescaler_ff <= prescaler_in;
         if (second_due) begin
            time_ff <= time_in;
         end
      end
   end

   // a second restarts the prescaler at one
   assert property (@(posedge clock) disable iff (reset)
      tick && second_due |=> prescaler_ff == 16'd1)
      else $error("prescaler not restarted after a second");

   // time only moves on a due tick
   assert property (@(posedge clock) disable iff (reset)
      !(tick && second_due) |=> $stable(time_ff))
      else $error("time changed without a second");

   // digits stay decimal
   assert property (@(posedge clock) disable iff (reset)
      time_ff.second_units <= 4'd9 && time_ff.minute_units <= 4'd9
      && time_ff.second_tens <= 3'd5 && time_ff.minute_tens <= 3'd5
      && time_ff.hour_tens <= 2'd2)
      else $error("time digit out of range");

endmodule

@@ rtl/bcd_clock_seven_segment_scan.sv @@
`timescale 1ns / 1ps
// 24-hour BCD clock driving a four-digit multiplexed seven-segment display.
// Each req word is one millisecond tick carrying the two mode-button levels; each
// tick yields exactly one rsp word for the digit scanned on that tick (one-hot
// digit_enable, bit0 leftmost, decimal point on digits 0 to 2). A tick is taken
// every clock cycle unless stalled, and its word appears in the next cycle from the
// output register, which is the only stage; req.ready drops only while that
// register holds a word the sink has not taken. The time resets to 15:30:00 and
// advances one second on the tick whose zero-based index equals ticks_per_second,
// then every ticks_per_second ticks (zero acts as one). After a sampled press the
// buttons are ignored for button_lockout minus one ticks; minutes-seconds wins
// when both are pressed. The displayed digit uses the time before that tick's
// advance. Write the csr registers only while no words are in flight.
module bcd_clock_seven_segment_scan (
   input  logic                                clock,
   input  logic                                reset,
   bcss_req_if.sink                            req_chan,
   bcss_rsp_if.source                          rsp_chan,
   input  logic                                csr_write_enable,
   input  logic                                csr_index,
   input  logic [bcss_pkg::CSR_DATA_WIDTH-1:0] csr_write_data
);
   import bcss_pkg::*;

   localparam logic [1:0] SCAN_DIGIT0 = 2'd0;
   localparam logic [1:0] SCAN_DIGIT1 = 2'd1;
   localparam logic [1:0] SCAN_DIGIT2 = 2'd2;
   localparam logic [1:0] SCAN_DIGIT3 = 2'd3;

   logic [15:0] ticks_per_second_ff;
   logic [15:0] button_lockout_ff;
   logic [15:0] lockout_ff, lockout_in, lockout_inc;
   logic        mode_ff, mode_in;
   logic [1:0]  scan_ff;
   logic        out_valid_ff;
   logic [6:0]  segments_ff;
   logic        decimal_point_ff;
   logic [3:0]  digit_enable_ff;
   logic        showing_ff;
   logic        advanced_ff;

   logic        accept;
   logic        sample;
   logic [3:0]  digit;
   time_type    now_time;
   logic        second_due;

   // take a tick whenever the output register is free or being drained
   assign req_chan.ready = !out_valid_ff || rsp_chan.ready;
   assign accept         = req_chan.valid && req_chan.ready;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         ticks_per_second_ff <= TICKS_PER_SECOND_RESET;
         button_lockout_ff   <= BUTTON_LOCKOUT_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_TICKS_PER_SECOND: ticks_per_second_ff <= csr_write_data;
            CSR_BUTTON_LOCKOUT:   button_lockout_ff   <= csr_write_data;
            default:              ;
         endcase
      end
   end

   bcss_timekeeper u_timekeeper (
      .clock            (clock),
      .reset            (reset),
      .tick             (accept),
      .ticks_per_second (ticks_per_second_ff),
      .now_time         (now_time),
      .second_due       (second_due)
   );

   // saturate the lockout count, then sample buttons once it has run out
   assign lockout_inc = (lockout_ff != COUNT_MAX) ? lockout_ff + 16'd1 : lockout_ff;
   assign sample      = (lockout_inc >= button_lockout_ff);

   always_comb begin
      lockout_in = lockout_inc;
      mode_in    = mode_ff;
      if (sample && req_chan.press_show_min_sec) begin
         lockout_in = 16'd0;
         mode_in    = 1'b1;
      end else if (sample && req_chan.press_show_hour_min) begin
         lockout_in = 16'd0;
         mode_in    = 1'b0;
      end
   end

   // pick the scanned digit from the current time and the updated mode
   always_comb begin
      case (scan_ff)
         SCAN_DIGIT0: digit = mode_in ? {1'b0, now_time.minute_tens}
                                      : {2'b00, now_time.hour_tens};
         SCAN_DIGIT1: digit = mode_in ? now_time.minute_units : now_time.hour_units;
         SCAN_DIGIT2: digit = mode_in ? {1'b0, now_time.second_tens}
                                      : {1'b0, now_time.minute_tens};
         default:     digit = mode_in ? now_time.second_units : now_time.minute_units;
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         lockout_ff   <= 16'd0;
         mode_ff      <= 1'b0;
         scan_ff      <= SCAN_DIGIT0;
         out_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            lockout_ff <= lockout_in;
            mode_ff    <= mode_in;
            scan_ff    <= scan_ff + 2'd1;
         end
         if (accept) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   // load the display word
   always_ff @(posedge clock) begin
      if (accept) begin
         segments_ff      <= seg_encode(digit);
         decimal_point_ff <= (scan_ff != SCAN_DIGIT3);
         digit_enable_ff  <= 4'b0001 << scan_ff;
         showing_ff       <= mode_in;
         advanced_ff      <= second_due;
      end
   end

   assign rsp_chan.valid           = out_valid_ff;
   assign rsp_chan.segments        = segments_ff;
   assign rsp_chan.decimal_point   = decimal_point_ff;
   assign rsp_chan.digit_enable    = digit_enable_ff;
   assign rsp_chan.showing_min_sec = showing_ff;
   assign rsp_chan.second_advanced = advanced_ff;

   // an accepted tick always leaves a word in the output register
   assert property (@(posedge clock) disable iff (reset)
      accept |=> out_valid_ff)
      else $error("accepted tick produced no word");

   // a pending word enables exactly one digit, point off only on the last
   assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> $onehot(digit_enable_ff) && (decimal_point_ff == !digit_enable_ff[3]))
      else $error("bad digit enable or decimal point");

   // a mode change clears the lockout count
   assert property (@(posedge clock) disable iff (reset)
      accept && (mode_in != mode_ff) |=> lockout_ff == 16'd0)
      else $error("mode changed without clearing lockout");

   // the scan only steps on an accepted tick
   assert property (@(posedge clock) disable iff (reset)
      !accept |=> $stable(scan_ff) && $stable(mode_ff))
      else $error("scan or mode moved without a tick");

endmodule
